[src/qcfc_pkg.sv]
// Shared types, widths and constants of the quaternion cell step block.
// Holds the controller command and status structs and the fixed-point helpers.
// Depends on nothing; every other file imports it.
`default_nettype none

package qcfc_pkg;

    localparam int LANE_W  = 16;
    localparam int QUAT_W  = 4 * LANE_W;
    localparam int ACC_W   = 36;
    localparam int V_W     = 54;
    localparam int TSUM_W  = 43;
    localparam int DIV_NW  = 44;
    localparam int DIV_DW  = 32;
    localparam int DIV_CW  = 6;
    localparam int SQ_W    = 62;
    localparam int SQRT_IW = 64;
    localparam int SQRT_RW = 32;
    localparam int SQRT_CW = 5;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 80;
    localparam int CFG_IW  = 2;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam logic [CFG_IW-1:0] CFG_IN_GAIN  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FB_GAIN  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_OUT_GAIN = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_TAU      = 2'd3;

    localparam logic [QUAT_W-1:0] RST_IN_GAIN  = 64'd4096;
    localparam logic [QUAT_W-1:0] RST_FB_GAIN  = 64'd0;
    localparam logic [QUAT_W-1:0] RST_OUT_GAIN = 64'd4096;
    localparam logic [QUAT_W-1:0] RST_TAU      = 64'd288234774265332736;
    localparam logic [QUAT_W-1:0] QUAT_IDENT   = 64'd4096;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAC_DRV,
        OP_TAU_DIV,
        OP_TAU_ACC,
        OP_EXP_X,
        OP_EXP_Y,
        OP_EXP_ACC,
        OP_DECAY,
        OP_MIX,
        OP_ABS,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT,
        OP_IDENT,
        OP_NDIV,
        OP_NS_WR,
        OP_MAC_OUT,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [CNT_W-1:0]   idx;
        logic               reject;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic in_dt_zero;
        logic shift_need;
        logic norm_zero;
    } dp_stat_t;

    // Integer square root, used only to build the constant root table.
    function automatic logic [63:0] isqrt_c(logic [63:0] v);
        logic [63:0] rem_v;
        logic [63:0] res_v;
        logic [63:0] bit_v;
        rem_v = v;
        res_v = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem_v >= res_v + bit_v) begin
                rem_v = rem_v - (res_v + bit_v);
                res_v = (res_v >> 1) + bit_v;
            end else begin
                res_v = res_v >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res_v;
    endfunction

    // Entry b holds 2^(-2^(b-16)) in Q.30, the factor for fraction bit b.
    function automatic logic [16*30-1:0] make_rtab();
        logic [16*30-1:0] tab;
        logic [63:0]      r;
        tab = '0;
        r   = isqrt_c(64'd1 << 59);
        for (int b = 15; b >= 0; b--) begin
            tab[b*30 +: 30] = r[29:0];
            r = isqrt_c(r << 30);
        end
        return tab;
    endfunction

    localparam logic [16*30-1:0] EXP_RTAB = make_rtab();

    function automatic logic signed [LANE_W-1:0] lane16(logic [QUAT_W-1:0] w, logic [1:0] i);
        return signed'(w[{i, 4'b0000} +: LANE_W]);
    endfunction

    // Hamilton product: lane k, term j multiplies a[j] by b[k^j]; these terms subtract.
    function automatic logic ham_neg(logic [1:0] k, logic [1:0] j);
        return (k == 2'd0 && j != 2'd0) || (k == 2'd1 && j == 2'd3) ||
               (k == 2'd2 && j == 2'd1) || (k == 2'd3 && j == 2'd2);
    endfunction

    // Q.24 to Q3.12, rounding half away from zero, saturated.
    function automatic logic [LANE_W-1:0] q24_sat(logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        logic [LANE_W-1:0] res;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        rnd = (mag + ACC_W'(2048)) >> 12;
        if (v[ACC_W-1]) begin
            res = (rnd > ACC_W'(32768)) ? 16'h8000 : LANE_W'(-rnd);
        end else begin
            res = (rnd > ACC_W'(32767)) ? 16'h7fff : rnd[LANE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/qcfc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the time-constant reciprocals and the normalization divides.
// Depends on qcfc_pkg.
`default_nettype none

module qcfc_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [qcfc_pkg::DIV_NW-1:0]  dividend,
    input  wire logic [qcfc_pkg::DIV_DW-1:0]  divisor,
    output logic                              busy,
    output logic [qcfc_pkg::DIV_NW-1:0]       quotient
);
    import qcfc_pkg::*;

    logic              busy_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_NW-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[src/qcfc_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
// Gives the floor of the root of the sum of squares.
// Depends on qcfc_pkg.
`default_nettype none

module qcfc_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [qcfc_pkg::SQRT_IW-1:0]  radicand,
    output logic                               busy,
    output logic [qcfc_pkg::SQRT_RW-1:0]       root
);
    import qcfc_pkg::*;

    logic               busy_reg;
    logic [SQRT_CW-1:0] cnt_reg;
    logic [SQRT_IW-1:0] src_reg;
    logic [33:0]        rem_reg;
    logic [SQRT_RW-1:0] root_reg;
    logic [35:0]        trial;
    logic [35:0]        test;
    logic [35:0]        diff;
    logic               fits;

    always_comb begin
        trial = {rem_reg, src_reg[SQRT_IW-1 -: 2]};
        test  = {2'b00, root_reg, 2'b01};
        fits  = trial >= test;
        diff  = trial - test;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CW'(SQRT_RW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            src_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            src_reg  <= {src_reg[SQRT_IW-3:0], 2'b00};
            rem_reg  <= fits ? diff[33:0] : trial[33:0];
            root_reg <= {root_reg[SQRT_RW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[src/qcfc_datapath.sv]
// Datapath of the cell step: configuration registers, cell state, a shared
// multiply-accumulate lane, the decay arithmetic, divider and square root.
// Depends on qcfc_pkg, qcfc_div and qcfc_sqrt.
`default_nettype none

module qcfc_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [qcfc_pkg::IN_W-1:0]    in_data,
    input  wire logic                         cfg_we,
    input  wire logic [qcfc_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [qcfc_pkg::QUAT_W-1:0]  cfg_wdata,
    input  wire qcfc_pkg::dp_cmd_t            cmd,
    output qcfc_pkg::dp_stat_t                stat,
    output logic [qcfc_pkg::QUAT_W-1:0]       out_data,
    output logic                              out_user
);
    import qcfc_pkg::*;

    logic [QUAT_W-1:0] gin_reg, gfb_reg, gout_reg, tau_reg;
    logic [QUAT_W-1:0] st_reg, qin_reg, ns_reg, out_reg;
    logic              out_user_reg;
    logic [15:0]       dt_reg;
    logic signed [ACC_W-1:0] acc_reg [4];
    logic [TSUM_W-1:0] tsum_reg;
    logic [30:0]       x_reg, eacc_reg;
    logic [31:0]       y_reg;
    logic [16:0]       decay_reg;
    logic signed [V_W-1:0] p_reg;
    logic signed [V_W-1:0] v_reg [4];
    logic [V_W-1:0]    mag_reg [4];
    logic [3:0]        neg_reg;
    logic [SQ_W-1:0]   sq_reg;

    logic [1:0]        mk, mj, ml;
    logic [QUAT_W-1:0] gword, bword;
    logic signed [31:0] mac_prod, mac_term;
    logic [15:0]       tau_lane;
    logic [58:0]       prod_x;
    logic [61:0]       prod_y;
    logic [3:0]        fbit;
    logic [60:0]       prod_e;
    logic [15:0]       n_int;
    logic [5:0]        sh;
    logic [30:0]       sh_val;
    logic [16:0]       dec_calc;
    logic [16:0]       comp;
    logic signed [17:0] comp_s, dec_s;
    logic signed [V_W-1:0] mix_p;
    logic signed [33:0] st_dec;
    logic [59:0]       sq_term;
    logic [14:0]       ns_rnd;
    logic              div_start, div_busy;
    logic [DIV_NW-1:0] div_dividend, div_q;
    logic [DIV_DW-1:0] div_divisor;
    logic              sqrt_busy;
    logic [SQRT_RW-1:0] norm;

    always_comb begin
        mk = cmd.idx[3:2];
        mj = cmd.idx[1:0];
        ml = cmd.idx[2:1];
        gword = (cmd.op == OP_MAC_OUT) ? gout_reg : (cmd.idx[4] ? gfb_reg : gin_reg);
        bword = (cmd.op == OP_MAC_OUT) ? ns_reg   : (cmd.idx[4] ? st_reg  : qin_reg);
        mac_prod = lane16(gword, mj) * lane16(bword, mk ^ mj);
        mac_term = ham_neg(mk, mj) ? -mac_prod : mac_prod;

        tau_lane = tau_reg[{cmd.idx[1:0], 4'b0000} +: 16];
        if (tau_lane == 16'd0) begin
            tau_lane = 16'd1;
        end

        prod_x = dt_reg * tsum_reg;
        prod_y = x_reg * LOG2E_Q30;
        fbit   = 4'(4'd15 - cmd.idx[3:0]);
        prod_e = eacc_reg * EXP_RTAB[int'(fbit)*30 +: 30] + 61'(1 << 29);

        n_int    = y_reg[31:16];
        sh       = 6'(n_int[5:0]) + 6'd13;
        sh_val   = eacc_reg >> sh;
        dec_calc = (n_int > 16'd40) ? 17'd0 : 17'(({1'b0, sh_val} + 32'd1) >> 1);
        comp     = 17'(18'd65536 - {1'b0, decay_reg});
        comp_s   = signed'({1'b0, comp});
        dec_s    = signed'({1'b0, decay_reg});
        mix_p    = acc_reg[ml] * comp_s;
        st_dec   = lane16(st_reg, ml) * dec_s;

        sq_term = mag_reg[cmd.idx[1:0]][29:0] * mag_reg[cmd.idx[1:0]][29:0];
        ns_rnd  = 15'((div_q[14:0] + 15'd1) >> 1);

        div_start    = (cmd.op == OP_TAU_DIV) || (cmd.op == OP_NDIV);
        div_dividend = (cmd.op == OP_TAU_DIV) ? DIV_NW'(1) << 40 :
                       {1'b0, mag_reg[cmd.idx[1:0]][29:0], 13'd0};
        div_divisor  = (cmd.op == OP_TAU_DIV) ? {16'd0, tau_lane} : norm;
    end

    qcfc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    qcfc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_SQRT),
        .radicand ({2'b00, sq_reg}),
        .busy     (sqrt_busy),
        .root     (norm)
    );

    // Configuration and cell state carry architectural reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gin_reg  <= RST_IN_GAIN;
            gfb_reg  <= RST_FB_GAIN;
            gout_reg <= RST_OUT_GAIN;
            tau_reg  <= RST_TAU;
            st_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IN_GAIN:  gin_reg  <= cfg_wdata;
                    CFG_FB_GAIN:  gfb_reg  <= cfg_wdata;
                    CFG_OUT_GAIN: gout_reg <= cfg_wdata;
                    CFG_TAU:      tau_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.op == OP_OUT_LOAD && !cmd.reject) begin
                st_reg <= ns_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                qin_reg  <= in_data[QUAT_W-1:0];
                dt_reg   <= in_data[IN_W-1:QUAT_W];
                tsum_reg <= '0;
                sq_reg   <= '0;
                for (int k = 0; k < 4; k++) begin
                    acc_reg[k] <= '0;
                end
            end
            OP_MAC_DRV, OP_MAC_OUT: begin
                acc_reg[mk] <= acc_reg[mk] + ACC_W'(mac_term);
            end
            OP_TAU_ACC: tsum_reg <= tsum_reg + div_q[TSUM_W-1:0];
            OP_EXP_X:   x_reg <= prod_x[58:28];
            OP_EXP_Y: begin
                y_reg    <= prod_y[61:30];
                eacc_reg <= 31'(1 << 30);
            end
            OP_EXP_ACC: begin
                if (y_reg[fbit]) begin
                    eacc_reg <= prod_e[60:30];
                end
            end
            OP_DECAY: decay_reg <= dec_calc;
            OP_MIX: begin
                if (!cmd.idx[0]) begin
                    p_reg <= mix_p;
                end else begin
                    v_reg[ml] <= p_reg + (V_W'(st_dec) <<< 12);
                end
            end
            OP_ABS: begin
                for (int k = 0; k < 4; k++) begin
                    mag_reg[k] <= v_reg[k][V_W-1] ? V_W'(-v_reg[k]) : V_W'(v_reg[k]);
                    neg_reg[k] <= v_reg[k][V_W-1];
                end
            end
            OP_SHIFT: begin
                for (int k = 0; k < 4; k++) begin
                    mag_reg[k] <= mag_reg[k] >> 1;
                end
            end
            OP_SQ: sq_reg <= sq_reg + SQ_W'(sq_term);
            OP_SQRT: begin
                for (int k = 0; k < 4; k++) begin
                    acc_reg[k] <= '0;
                end
            end
            OP_IDENT: ns_reg <= QUAT_IDENT;
            OP_NS_WR: begin
                ns_reg[{cmd.idx[1:0], 4'b0000} +: 16] <=
                    neg_reg[cmd.idx[1:0]] ? 16'(-{1'b0, ns_rnd}) : 16'(ns_rnd);
            end
            OP_OUT_LOAD: begin
                out_user_reg <= cmd.reject;
                for (int k = 0; k < 4; k++) begin
                    out_reg[k*16 +: 16] <= cmd.reject ? 16'd0 : q24_sat(acc_reg[k]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.div_busy   = div_busy;
        stat.sqrt_busy  = sqrt_busy;
        stat.in_dt_zero = (in_data[IN_W-1:QUAT_W] == 16'd0);
        stat.shift_need = (mag_reg[0][V_W-1:30] != '0) || (mag_reg[1][V_W-1:30] != '0) ||
                          (mag_reg[2][V_W-1:30] != '0) || (mag_reg[3][V_W-1:30] != '0);
        stat.norm_zero  = (norm == '0);
    end

    assign out_data = out_reg;
    assign out_user = out_user_reg;

endmodule

`default_nettype wire

[src/qcfc_ctrl.sv]
// Sequencer of the cell step: walks one item through the datapath phases
// and owns the input ready and output valid handshake flags.
// Depends on qcfc_pkg.
`default_nettype none

module qcfc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire qcfc_pkg::dp_stat_t  stat,
    output qcfc_pkg::dp_cmd_t        cmd
);
    import qcfc_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_DRV   = 18'h00002,
        ST_TDIV  = 18'h00004,
        ST_TWAIT = 18'h00008,
        ST_EXPX  = 18'h00010,
        ST_EXPY  = 18'h00020,
        ST_EXPA  = 18'h00040,
        ST_DECAY = 18'h00080,
        ST_MIX   = 18'h00100,
        ST_ABS   = 18'h00200,
        ST_SHIFT = 18'h00400,
        ST_SQ    = 18'h00800,
        ST_SQRT  = 18'h01000,
        ST_SWAIT = 18'h02000,
        ST_NDIV  = 18'h04000,
        ST_NWAIT = 18'h08000,
        ST_OMAC  = 18'h10000,
        ST_DONE  = 18'h20000
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rej_reg, rej_next;
    logic             mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rej_next   = rej_reg;
        mv_next    = mv_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg;
        cmd.reject = rej_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    rej_next   = stat.in_dt_zero;
                    cnt_next   = '0;
                    state_next = stat.in_dt_zero ? ST_DONE : ST_DRV;
                end
            end
            ST_DRV: begin
                cmd.op   = OP_MAC_DRV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(31)) begin
                    cnt_next   = '0;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                cmd.op     = OP_TAU_DIV;
                state_next = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op = OP_TAU_ACC;
                    if (cnt_reg == CNT_W'(3)) begin
                        state_next = ST_EXPX;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_TDIV;
                    end
                end
            end
            ST_EXPX: begin
                cmd.op     = OP_EXP_X;
                state_next = ST_EXPY;
            end
            ST_EXPY: begin
                cmd.op     = OP_EXP_Y;
                cnt_next   = '0;
                state_next = ST_EXPA;
            end
            ST_EXPA: begin
                cmd.op   = OP_EXP_ACC;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(15)) begin
                    state_next = ST_DECAY;
                end
            end
            ST_DECAY: begin
                cmd.op     = OP_DECAY;
                cnt_next   = '0;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.op   = OP_MIX;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(7)) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                cmd.op     = OP_ABS;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (stat.shift_need) begin
                    cmd.op = OP_SHIFT;
                end else begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3)) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.op     = OP_SQRT;
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (!stat.sqrt_busy) begin
                    cnt_next = '0;
                    if (stat.norm_zero) begin
                        cmd.op     = OP_IDENT;
                        state_next = ST_OMAC;
                    end else begin
                        state_next = ST_NDIV;
                    end
                end
            end
            ST_NDIV: begin
                cmd.op     = OP_NDIV;
                state_next = ST_NWAIT;
            end
            ST_NWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op = OP_NS_WR;
                    if (cnt_reg == CNT_W'(3)) begin
                        cnt_next   = '0;
                        state_next = ST_OMAC;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_NDIV;
                    end
                end
            end
            ST_OMAC: begin
                cmd.op   = OP_MAC_OUT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(15)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    cmd.op     = OP_OUT_LOAD;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rej_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rej_reg   <= rej_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

endmodule

`default_nettype wire

[src/quaternion_cfc_cell_step_top.sv]
// Top level of the quaternion closed-form continuous-time cell step.
// Joins the sequencer (qcfc_ctrl) and the datapath (qcfc_datapath).
// Depends on qcfc_pkg and both modules.
//
// One input word carries a Q3.12 quaternion and a Q4.12 time step. The block
// forms the drive, the input gain (x) q plus the feedback gain (x) state, with
// Hamilton products, computes decay = exp(-dt/tau_hm), where tau_hm is the
// harmonic mean of the four Q6.10 time constants, blends state and drive,
// normalizes the blend back to a unit quaternion (the identity if it
// vanishes) and returns the output gain (x) new state, rounded and saturated
// to Q3.12. One result word comes out for each input word. A zero time step
// is rejected: the result word is zero with the status flag set, and the
// state is left untouched.
// Items are handled one at a time. A step loads the word, forms the drive
// with multiply-accumulate steps, runs four reciprocal divides on the shared
// 44-bit divider (each a start, 44 quotient bits and the accumulate), then
// the decay, the blend, the magnitudes, the normalizing shifts until a check
// finds no shift left, the squaring, the square root, four more divides for
// the normalization, the output product and the load of the output word.
// When the blend vanishes the normalizing divides are skipped. The shared
// divider takes most of a step. A rejected step goes straight from the load
// to the output word. A result word that the sink has not yet taken holds the
// block in its final state until the sink takes it. The next word is taken
// once the previous result has moved into the output register, even if the
// sink has not yet accepted it. Configuration registers are to be written
// by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module quaternion_cfc_cell_step_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata, from bit 0 up: in_w, in_x, in_y, in_z, step_dt (16 bits each).
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // m_tdata, from bit 0 up: out_w, out_x, out_y, out_z (16 bits each).
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    // m_tuser: status (1 when the time step was rejected).
    output logic             m_tuser,
    // Register 0 input gain, 1 feedback gain, 2 output gain, 3 time constants.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    import qcfc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The sequencer issues at most one datapath command per cycle and watches
    // the divider, square root and shift status to decide when to move on.
    qcfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds configuration, the cell state and the output word.
    qcfc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire

[bench/tb_quaternion_cfc_cell_step_top.sv]
// Self-checking bench for the quaternion closed-form continuous-time cell step.
// A scoreboard class predicts every result word; a task and a process drive the ports.
// Depends on qcfc_pkg and quaternion_cfc_cell_step_top.
`timescale 1ns / 100ps

import qcfc_pkg::*;

// Predicts the cell step from its own copy of the state and the registers and
// keeps the queue of result words that are still due.
class cell_scoreboard;
    logic [63:0] in_gain, fb_gain, out_gain, tau_lanes, cell_state;
    logic [64:0] due_q[$];   // {status, out_z, out_y, out_x, out_w}
    int          errors;

    function new();
        in_gain    = RST_IN_GAIN;
        fb_gain    = RST_FB_GAIN;
        out_gain   = RST_OUT_GAIN;
        tau_lanes  = RST_TAU;
        cell_state = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
        case (idx)
            CFG_IN_GAIN:  in_gain   = val;
            CFG_FB_GAIN:  fb_gain   = val;
            CFG_OUT_GAIN: out_gain  = val;
            CFG_TAU:      tau_lanes = val;
        endcase
    endfunction

    static function longint lane_of(logic [63:0] w, int k);
        logic [15:0] l;
        l = w[16*k +: 16];
        return longint'(signed'(l));
    endfunction

    static function logic [63:0] root64(logic [63:0] v);
        logic [63:0] rem_v, res_v, bit_v;
        rem_v = v;
        res_v = '0;
        bit_v = 64'd1 << 62;
        repeat (32) begin
            if (rem_v >= res_v + bit_v) begin
                rem_v = rem_v - (res_v + bit_v);
                res_v = (res_v >> 1) + bit_v;
            end else begin
                res_v = res_v >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res_v;
    endfunction

    static function void hamilton(input longint a[4], input longint b[4], output longint r[4]);
        r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        r[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
        r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    endfunction

    // exp(-dt/tau_hm) in Q.16, tau_hm the harmonic mean of the time constants,
    // through a power of two built bit by bit.
    function logic [63:0] decay_of(logic [63:0] dt);
        logic [63:0] s, x, y, n, f, acc, r, t;
        s = 0;
        for (int k = 0; k < 4; k++) begin
            t = tau_lanes[16*k +: 16];
            if (t == 0) t = 1;
            s += (64'd1 << 40) / t;
        end
        x   = (dt * s) >> 28;
        y   = (x * 64'd1549082005) >> 30;
        n   = y >> 16;
        f   = y & 64'hFFFF;
        acc = 64'd1 << 30;
        r   = root64(64'd1 << 59);
        for (int b = 15; b >= 0; b--) begin
            if (f[b]) acc = (acc * r + (64'd1 << 29)) >> 30;
            r = root64(r << 30);
        end
        if (n > 40) return 0;
        return ((acc >> (13 + n)) + 1) >> 1;
    endfunction

    static function logic [15:0] to_out(longint v);
        logic [63:0] mag;
        mag = v < 0 ? -v : v;
        mag = (mag + 2048) >> 12;
        if (v < 0) return mag > 32768 ? 16'h8000 : 16'(-mag);
        return mag > 32767 ? 16'h7fff : mag[15:0];
    endfunction

    // Called for every accepted input word.
    function void note_input(logic [79:0] w);
        longint qin[4], st[4], g[4], t1[4], t2[4], v[4], ns[4];
        logic [63:0] dt, dec, comp, m, sum, norm, a;
        logic [63:0] res;
        int sh;
        dt = w[79:64];
        if (dt == 0) begin
            due_q.push_back({1'b1, 64'd0});
            return;
        end
        for (int k = 0; k < 4; k++) begin
            qin[k] = lane_of(w[63:0], k);
            st[k]  = lane_of(cell_state, k);
            g[k]   = lane_of(in_gain, k);
        end
        hamilton(g, qin, t1);
        for (int k = 0; k < 4; k++) g[k] = lane_of(fb_gain, k);
        hamilton(g, st, t2);
        dec  = decay_of(dt);
        comp = 65536 - dec;
        m    = 0;
        for (int k = 0; k < 4; k++) begin
            v[k] = st[k] * longint'(dec) * 4096 + (t1[k] + t2[k]) * longint'(comp);
            a = v[k] < 0 ? -v[k] : v[k];
            if (a > m) m = a;
        end
        sh = 0;
        while ((m >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            a = (v[k] < 0 ? -v[k] : v[k]) >> sh;
            v[k] = v[k] < 0 ? -longint'(a) : longint'(a);
            sum += a * a;
        end
        norm = root64(sum);
        // A blend that vanishes resets the state to the identity.
        if (norm == 0) begin
            ns = '{4096, 0, 0, 0};
        end else begin
            for (int k = 0; k < 4; k++) begin
                a = (((v[k] < 0 ? -v[k] : v[k]) * 8192) / norm + 1) >> 1;
                ns[k] = v[k] < 0 ? -longint'(a) : longint'(a);
            end
        end
        for (int k = 0; k < 4; k++) begin
            cell_state[16*k +: 16] = ns[k][15:0];
            g[k] = lane_of(out_gain, k);
        end
        hamilton(g, ns, t1);
        for (int k = 0; k < 4; k++) res[16*k +: 16] = to_out(t1[k]);
        due_q.push_back({1'b0, res});
    endfunction

    // Called for every accepted result word.
    function void check_result(logic [63:0] data, logic user);
        logic [64:0] exp_w;
        if (due_q.size() == 0) begin
            $display("%0t: result word with none due: data %h user %b", $time, data, user);
            errors++;
            return;
        end
        exp_w = due_q.pop_front();
        for (int k = 0; k < 4; k++)
            if (data[16*k +: 16] !== exp_w[16*k +: 16]) begin
                $display("%0t: lane %0d expected %h actual %h",
                         $time, k, exp_w[16*k +: 16], data[16*k +: 16]);
                errors++;
            end
        if (user !== exp_w[64]) begin
            $display("%0t: status expected %b actual %b", $time, exp_w[64], user);
            errors++;
        end
    endfunction
endclass

module tb_quaternion_cfc_cell_step_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // from bit 0 up: in_w, in_x, in_y, in_z, step_dt
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // from bit 0 up: out_w, out_x, out_y, out_z
    logic        m_tuser;    // status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;

    cell_scoreboard sb = new();
    bit calm;          // set for the last part of the run: no idling anywhere
    int sink_hold;

    quaternion_cfc_cell_step_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Even a slow run stays far below this time limit.
    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    // The sink checks every accepted word and then decides whether to stall.
    // Stalls come in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (calm) begin
            m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            sink_hold <= $urandom_range(0, 3);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Lane picker that favors the edges of the Q3.12 range.
    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'd4096;
            4: return 16'(-4096);
            5: return 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(1, 16));
            3, 4: return 16'($urandom_range(1, 1024));
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one word and waits for it to be taken; may then idle for a burst.
    task automatic send_word(input logic [79:0] w);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(w);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Lets every due word drain and then idles before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // The enable drops for one cycle after each write, so back-to-back calls
    // never assign it twice in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_quat();
        return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
    endfunction

    initial begin
        logic [63:0] tau_v;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        m_tready  = 0;
        cfg_we    = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        calm      = 0;
        sink_hold = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset registers. The first one sees a zero
        // state and a zero input, so the blend vanishes and the state becomes
        // the identity.
        send_word({16'd4096, 64'd0});
        send_word({16'd0, 64'h1234_5678_9abc_def0});      // zero time step is rejected
        send_word({16'hffff, {4{16'h7fff}}});
        send_word({16'd1, {4{16'h8000}}});
        send_word({16'd1, 64'h0000_0000_0000_1000});
        send_word({16'hffff, 64'h8000_7fff_8000_7fff});
        send_word({16'd0, {4{16'hffff}}});
        send_word({16'h0800, 64'hffff_0000_ffff_0000});
        drain();

        // Extremes of the registers: saturating gains and the shortest and
        // longest time constants.
        write_reg(CFG_IN_GAIN, {4{16'h7fff}});
        write_reg(CFG_FB_GAIN, {4{16'h8000}});
        write_reg(CFG_OUT_GAIN, {4{16'h7fff}});
        write_reg(CFG_TAU, 64'd0);
        send_word({16'd1, {4{16'h7fff}}});
        send_word({16'hffff, {4{16'h8000}}});
        send_word({16'd1, 64'd0});
        send_word({16'h0010, 64'h7fff_8000_7fff_8000});
        drain();
        write_reg(CFG_TAU, {4{16'hffff}});
        write_reg(CFG_FB_GAIN, {4{16'h7fff}});
        write_reg(CFG_OUT_GAIN, {4{16'h8000}});
        write_reg(CFG_IN_GAIN, 64'd0);
        send_word({16'd1, {4{16'h7fff}}});
        send_word({16'hffff, {4{16'h8000}}});
        send_word({16'd0, 64'd0});
        send_word({16'd100, 64'h0001_0002_0003_0004});
        drain();

        // Random phases, each under fresh register values.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_IN_GAIN, pick_quat());
            write_reg(CFG_FB_GAIN, ($urandom_range(0, 2) == 0) ? 64'd0 : pick_quat());
            write_reg(CFG_OUT_GAIN, pick_quat());
            case ($urandom_range(0, 3))
                0: tau_v = {$urandom, $urandom};
                1: tau_v = {16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                            16'($urandom_range(0, 4)), 16'($urandom_range(0, 4))};
                default: tau_v = {16'($urandom_range(256, 8192)), 16'($urandom_range(256, 8192)),
                                  16'($urandom_range(256, 8192)), 16'($urandom_range(256, 8192))};
            endcase
            write_reg(CFG_TAU, tau_v);
            if (ph == 7) calm = 1;
            repeat (160) send_word({pick_dt(), pick_quat()});
            drain();
        end

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
